@@ sv/mfam_pkg.sv @@
// ---------------------------------------------------------------------------
// mfam_pkg
// Shared types and constants for the minifloat add / multiply unit.
// ---------------------------------------------------------------------------
package mfam_pkg;

	// minifloat word layout
	localparam int unsigned WORD_W = 14;
	localparam int unsigned EXP_W  = 6;
	localparam int unsigned FRAC_W = 8;
	localparam int unsigned SIG_W  = FRAC_W + 1;
	localparam int unsigned PROD_W = 2 * SIG_W;

	localparam logic [EXP_W-1:0] EXP_ZERO = '0;
	localparam logic [EXP_W-1:0] EXP_MAX  = '1;
	localparam logic [7:0]       BIAS     = 8'd31;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_SPECIAL = 2'd2,
		ST_OVER    = 2'd3
	} status_t;

	// one computed result
	typedef struct packed {
		logic [WORD_W-1:0] value;
		status_t           status;
	} result_t;

endpackage

@@ sv/mfam_core.sv @@
// ---------------------------------------------------------------------------
// mfam_core
// Combinational minifloat add / multiply with truncation and status.
// ---------------------------------------------------------------------------
module mfam_core (
	input  logic                          op,
	input  logic [mfam_pkg::WORD_W-1:0]   operand_a,
	input  logic [mfam_pkg::WORD_W-1:0]   operand_b,
	output mfam_pkg::result_t             res
);

	logic [mfam_pkg::EXP_W-1:0]  ea, eb;
	logic [mfam_pkg::SIG_W-1:0]  sig_a, sig_b;
	logic                        any_zero, any_special;

	// field split with hidden one
	assign ea    = operand_a[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W];
	assign eb    = operand_b[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W];
	assign sig_a = {1'b1, operand_a[mfam_pkg::FRAC_W-1:0]};
	assign sig_b = {1'b1, operand_b[mfam_pkg::FRAC_W-1:0]};

	assign any_zero    = (ea == mfam_pkg::EXP_ZERO) || (eb == mfam_pkg::EXP_ZERO);
	assign any_special = (ea == mfam_pkg::EXP_MAX) || (eb == mfam_pkg::EXP_MAX);

	// addition path: pick large operand, align small one
	logic                         a_large;
	logic [mfam_pkg::EXP_W-1:0]   lg_e, sm_e, diff;
	logic [mfam_pkg::SIG_W-1:0]   lg_sig, sm_sig, sm_aligned;
	logic [mfam_pkg::WORD_W-1:0]  lg_word;
	logic [mfam_pkg::SIG_W:0]     sum;
	logic [mfam_pkg::EXP_W:0]     add_e;
	logic [mfam_pkg::FRAC_W-1:0]  add_frac;
	logic                         far_apart;

	assign a_large    = (ea >= eb);
	assign lg_e       = a_large ? ea : eb;
	assign sm_e       = a_large ? eb : ea;
	assign lg_sig     = a_large ? sig_a : sig_b;
	assign sm_sig     = a_large ? sig_b : sig_a;
	assign lg_word    = a_large ? operand_a : operand_b;
	assign diff       = lg_e - sm_e;
	assign far_apart  = (diff > mfam_pkg::EXP_W'(mfam_pkg::FRAC_W));
	assign sm_aligned = sm_sig >> diff[3:0];
	assign sum        = {1'b0, lg_sig} + {1'b0, sm_aligned};
	assign add_e      = {1'b0, lg_e} + {{mfam_pkg::EXP_W{1'b0}}, sum[mfam_pkg::SIG_W]};
	assign add_frac   = sum[mfam_pkg::SIG_W] ? sum[mfam_pkg::FRAC_W:1]
	                                         : sum[mfam_pkg::FRAC_W-1:0];

	// multiplication path: exact 9x9 product, renormalize by one
	logic [mfam_pkg::PROD_W-1:0]  prod;
	logic                         prod_carry;
	logic [7:0]                   mul_e;
	logic [mfam_pkg::FRAC_W-1:0]  mul_frac;
	logic                         mul_under, mul_over;

	assign prod       = {{mfam_pkg::SIG_W{1'b0}}, sig_a} * {{mfam_pkg::SIG_W{1'b0}}, sig_b};
	assign prod_carry = prod[mfam_pkg::PROD_W-1];
	assign mul_e      = {2'b00, ea} + {2'b00, eb} + {7'b0, prod_carry} - mfam_pkg::BIAS;
	assign mul_frac   = prod_carry ? prod[mfam_pkg::PROD_W-2:mfam_pkg::SIG_W]
	                               : prod[mfam_pkg::PROD_W-3:mfam_pkg::FRAC_W];
	assign mul_under  = mul_e[7] || (mul_e == 8'd0);
	assign mul_over   = !mul_e[7] && (mul_e[6:0] >= {1'b0, mfam_pkg::EXP_MAX});

	// result selection
	always_comb begin
		res.value  = '0;
		res.status = mfam_pkg::ST_OK;
		if (any_zero) begin
			res.status = mfam_pkg::ST_ZERO;
		end else if (any_special) begin
			res.status = mfam_pkg::ST_SPECIAL;
		end else if (!op) begin
			if (far_apart) begin
				res.value = lg_word;
			end else if (add_e >= {1'b0, mfam_pkg::EXP_MAX}) begin
				res.status = mfam_pkg::ST_OVER;
			end else begin
				res.value = {add_e[mfam_pkg::EXP_W-1:0], add_frac};
			end
		end else begin
			if (mul_under) begin
				res.status = mfam_pkg::ST_ZERO;
			end else if (mul_over) begin
				res.status = mfam_pkg::ST_OVER;
			end else begin
				res.value = {mul_e[mfam_pkg::EXP_W-1:0], mul_frac};
			end
		end
	end

endmodule

@@ sv/minifloat_add_mul_unit.sv @@
// ---------------------------------------------------------------------------
// minifloat_add_mul_unit
// Adds or multiplies two 14-bit unsigned minifloats, truncating the result.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: op (0 add,
//   1 multiply) and the two operands. Output channel (out_valid /
//   out_stall) returns one item per input: result_value and status.
//   An item is moved at a clock edge where valid is high and stall low.
// Path: an accepted input item is held in the operand register, passes
//   through the arithmetic into the result register, and out_valid then
//   rises; the result is taken at an edge where out_stall is low.
// Throughput: one item per cycle while out_stall stays low; a 9x9
//   multiply and one aligned add set the single stage of logic.
// Stall: when out_stall holds, the result register keeps its item and
//   the operand register can still take one more item; in_stall rises
//   only once both registers hold items and the output is stalled.
// Reset: arst_n clears both valid flags; no item is in flight afterwards.
// ---------------------------------------------------------------------------
module minifloat_add_mul_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [mfam_pkg::WORD_W-1:0]  operand_a,
	input  logic [mfam_pkg::WORD_W-1:0]  operand_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mfam_pkg::WORD_W-1:0]  result_value,
	output logic [1:0]                   status
);

	logic                         valid_s1, valid_s2;
	logic                         op_s1;
	logic [mfam_pkg::WORD_W-1:0]  a_s1, b_s1;
	mfam_pkg::result_t            res_c, res_s2;
	logic                         adv_s1, adv_s2;

	// pipeline advance
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// operand register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1 <= op;
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	// arithmetic
	mfam_core u_core (
		.op        (op_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.res       (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid    = valid_s2;
	assign result_value = res_s2.value;
	assign status       = res_s2.status;

endmodule

@@ sv/mfam_checker.sv @@
// ---------------------------------------------------------------------------
// mfam_checker
// Port-level checks for the minifloat add / multiply unit.
// ---------------------------------------------------------------------------
module mfam_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mfam_pkg::WORD_W-1:0]  result_value,
	input logic [1:0]                   status
);

	// stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
		else $error("stalled output item changed");

	// input backpressure only when output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// accepted item passes both registers to the output when not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("item did not reach output");

	// non-ok status carries zero value
	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != mfam_pkg::ST_OK) |-> result_value == '0)
		else $error("nonzero value with non-ok status");

endmodule

bind minifloat_add_mul_unit mfam_checker u_mfam_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.status       (status)
);

@@ verif/tb_minifloat_add_mul_unit.sv @@
// ---------------------------------------------------------------------------
// tb_minifloat_add_mul_unit
// Self-checking bench for the minifloat add / multiply unit: a short table of
// directed operand pairs, then about 1500 random pairs under three mixes of
// sender and receiver idling and one long output hold. Every result is
// compared field by field with an in-order queue of predicted results.
// ---------------------------------------------------------------------------
module tb_minifloat_add_mul_unit;

	localparam int          CLK_PERIOD   = 4;
	localparam int          RESET_CYCLES = 11;
	localparam int          PHASE_ITEMS  = 500;
	localparam int          HOLD_CYCLES  = 120;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          STALL_LIMIT  = 2000;
	localparam logic        OP_ADD       = 1'b0;
	localparam logic        OP_MUL       = 1'b1;
	localparam logic        PREDICT      = 1'b0;
	localparam logic        TYPED        = 1'b1;
	localparam int          NUM_ROWS     = 23;

	// one operand pair, with a typed expectation where it is obvious
	typedef struct packed {
		logic                        op;
		logic [mfam_pkg::WORD_W-1:0] a;
		logic [mfam_pkg::WORD_W-1:0] b;
		logic                        typed;
		mfam_pkg::result_t           want;
	} vec_t;

	localparam vec_t DIRECTED [NUM_ROWS] = '{
		'{OP_ADD, 14'h0000, 14'h1F00, TYPED,   '{14'h0000, mfam_pkg::ST_ZERO}},
		'{OP_MUL, 14'h00FF, 14'h3FFF, TYPED,   '{14'h0000, mfam_pkg::ST_ZERO}},
		'{OP_ADD, 14'h3F00, 14'h1F00, TYPED,   '{14'h0000, mfam_pkg::ST_SPECIAL}},
		'{OP_MUL, 14'h3FFF, 14'h3FFF, TYPED,   '{14'h0000, mfam_pkg::ST_SPECIAL}},
		'{OP_ADD, 14'h1F00, 14'h1F00, TYPED,   '{14'h2000, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h0100, 14'h0100, TYPED,   '{14'h0200, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h3000, 14'h2700, TYPED,   '{14'h3000, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h0100, 14'h3E80, TYPED,   '{14'h3E80, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h3000, 14'h28FF, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h1F80, 14'h1F40, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h3EFF, 14'h3EFF, TYPED,   '{14'h0000, mfam_pkg::ST_OVER}},
		'{OP_ADD, 14'h3E00, 14'h3D00, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_ADD, 14'h01FF, 14'h3EFF, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h1F00, 14'h1F00, TYPED,   '{14'h1F00, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h0100, 14'h1F00, TYPED,   '{14'h0100, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h0100, 14'h0100, TYPED,   '{14'h0000, mfam_pkg::ST_ZERO}},
		'{OP_MUL, 14'h0F00, 14'h1000, TYPED,   '{14'h0000, mfam_pkg::ST_ZERO}},
		'{OP_MUL, 14'h0FFF, 14'h10FF, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h3E00, 14'h1F00, TYPED,   '{14'h3E00, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h3EFF, 14'h1FFF, TYPED,   '{14'h0000, mfam_pkg::ST_OVER}},
		'{OP_MUL, 14'h3E00, 14'h3E00, TYPED,   '{14'h0000, mfam_pkg::ST_OVER}},
		'{OP_MUL, 14'h1FFF, 14'h1FFF, PREDICT, '{14'h0000, mfam_pkg::ST_OK}},
		'{OP_MUL, 14'h2080, 14'h1D55, PREDICT, '{14'h0000, mfam_pkg::ST_OK}}
	};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic                        op        = OP_ADD;
	logic [mfam_pkg::WORD_W-1:0] operand_a = '0;
	logic [mfam_pkg::WORD_W-1:0] operand_b = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [mfam_pkg::WORD_W-1:0] result_value;
	logic [1:0]                  status;

	mfam_pkg::result_t cur_expect = '{value: '0, status: mfam_pkg::ST_OK};
	mfam_pkg::result_t pending_results [$];
	int unsigned send_idle_pct  = 34;
	int unsigned recv_stall_pct = 52;
	bit          hold_armed     = 1'b0;
	int unsigned errors         = 0;
	int unsigned add_count      = 0;
	int unsigned mul_count      = 0;
	int unsigned status_seen [4] = '{0, 0, 0, 0};

	minifloat_add_mul_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// sum or product of two minifloats, truncated, with its status
	function automatic mfam_pkg::result_t mf_compute(logic opcode,
			logic [mfam_pkg::WORD_W-1:0] a, logic [mfam_pkg::WORD_W-1:0] b);
		logic [mfam_pkg::EXP_W-1:0]  ea;
		logic [mfam_pkg::EXP_W-1:0]  eb;
		logic [mfam_pkg::EXP_W-1:0]  diff;
		logic [mfam_pkg::SIG_W-1:0]  sig_a;
		logic [mfam_pkg::SIG_W-1:0]  sig_b;
		logic [mfam_pkg::SIG_W-1:0]  sig_lg;
		logic [mfam_pkg::SIG_W-1:0]  sig_sm;
		logic [mfam_pkg::WORD_W-1:0] word_lg;
		logic [mfam_pkg::PROD_W-1:0] acc;
		int                          e;
		mfam_pkg::result_t           r;
		ea    = a[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W];
		eb    = b[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W];
		sig_a = {1'b1, a[mfam_pkg::FRAC_W-1:0]};
		sig_b = {1'b1, b[mfam_pkg::FRAC_W-1:0]};
		r     = '{value: '0, status: mfam_pkg::ST_OK};
		if (ea == mfam_pkg::EXP_ZERO || eb == mfam_pkg::EXP_ZERO) begin
			r.status = mfam_pkg::ST_ZERO;
		end else if (ea == mfam_pkg::EXP_MAX || eb == mfam_pkg::EXP_MAX) begin
			r.status = mfam_pkg::ST_SPECIAL;
		end else if (opcode == OP_ADD) begin
			// operand_a counts as the larger one on equal exponents
			if (ea >= eb) begin
				word_lg = a; sig_lg = sig_a; sig_sm = sig_b; e = int'(ea); diff = ea - eb;
			end else begin
				word_lg = b; sig_lg = sig_b; sig_sm = sig_a; e = int'(eb); diff = eb - ea;
			end
			if (diff > mfam_pkg::FRAC_W) begin
				r.value = word_lg;
			end else begin
				acc = ((mfam_pkg::PROD_W'(sig_lg) << diff) + mfam_pkg::PROD_W'(sig_sm)) >> diff;
				if (acc[mfam_pkg::SIG_W]) begin
					acc = acc >> 1;
					e++;
				end
				if (e >= int'(mfam_pkg::EXP_MAX))
					r.status = mfam_pkg::ST_OVER;
				else
					r.value = {e[mfam_pkg::EXP_W-1:0], acc[mfam_pkg::FRAC_W-1:0]};
			end
		end else begin
			// exact 18-bit product, renormalized once
			e   = int'(ea) + int'(eb) - int'(mfam_pkg::BIAS);
			acc = mfam_pkg::PROD_W'(sig_a) * mfam_pkg::PROD_W'(sig_b);
			if (acc[mfam_pkg::PROD_W-1]) begin
				acc = acc >> 1;
				e++;
			end
			if (e <= 0)
				r.status = mfam_pkg::ST_ZERO;
			else if (e >= int'(mfam_pkg::EXP_MAX))
				r.status = mfam_pkg::ST_OVER;
			else
				r.value = {e[mfam_pkg::EXP_W-1:0],
					acc[2*mfam_pkg::FRAC_W-1 -: mfam_pkg::FRAC_W]};
		end
		return r;
	endfunction

	// mostly in-range pairs near the interesting exponents, some noise
	function automatic vec_t make_random_pair();
		vec_t        v;
		int unsigned pick;
		int          ea;
		int          eb;
		pick    = $urandom_range(0, 99);
		v.op    = 1'($urandom_range(0, 1));
		v.typed = PREDICT;
		v.want  = '{value: '0, status: mfam_pkg::ST_OK};
		ea      = int'($urandom_range(1, 62));
		if (v.op == OP_ADD)
			eb = ea + int'($urandom_range(0, 22)) - 11;
		else
			eb = int'($urandom_range(0, 69)) - 3 + int'(mfam_pkg::BIAS) - ea;
		if (eb < 1) eb = 1;
		if (eb > 62) eb = 62;
		v.a = {mfam_pkg::EXP_W'(ea), mfam_pkg::FRAC_W'($urandom)};
		v.b = {mfam_pkg::EXP_W'(eb), mfam_pkg::FRAC_W'($urandom)};
		if (pick < 10) begin
			v.a = mfam_pkg::WORD_W'($urandom);
			v.b = mfam_pkg::WORD_W'($urandom);
		end else if (pick < 14) begin
			if (pick[0]) v.a[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W] = mfam_pkg::EXP_ZERO;
			else         v.b[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W] = mfam_pkg::EXP_ZERO;
		end else if (pick < 18) begin
			if (pick[0]) v.a[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W] = mfam_pkg::EXP_MAX;
			else         v.b[mfam_pkg::WORD_W-1:mfam_pkg::FRAC_W] = mfam_pkg::EXP_MAX;
		end else if (pick < 26) begin
			v.a[mfam_pkg::FRAC_W-1:0] = '1;
			v.b[mfam_pkg::FRAC_W-1:0] = '1;
		end
		return v;
	endfunction

	// offer one item, idling first at the sender's rate, until it is taken
	task automatic offer_item(input vec_t v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= v.op;
		operand_a  <= v.a;
		operand_b  <= v.b;
		cur_expect <= v.typed ? v.want : mf_compute(v.op, v.a, v.b);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count) offer_item(make_random_pair());
	endtask

	// receiver stalls at random, or holds off for a long stretch when armed
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_armed = 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// queue expectations on input items, check output items in order
	always @(posedge clk) begin : check_results
		mfam_pkg::result_t want;
		if (arst_n && in_valid && !in_stall) begin
			pending_results.push_back(cur_expect);
			if (op == OP_MUL) mul_count++;
			else add_count++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item value=%h status=%0d",
					$time, result_value, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				status_seen[want.status]++;
				if (result_value !== want.value) begin
					$display("%0t: result_value expected %h actual %h",
						$time, want.value, result_value);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					errors++;
				end
			end
		end
	end

	// end the run when no item moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : main_sequence
		int unsigned row;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (row = 0; row < NUM_ROWS; row++)
			offer_item(DIRECTED[row]);

		// sender idles less than receiver
		run_random(PHASE_ITEMS);

		// roles swapped
		send_idle_pct  = 52;
		recv_stall_pct = 34;
		run_random(PHASE_ITEMS);

		// no idling, with one long receiver hold to back up the input
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_armed     = 1'b1;
		run_random(PHASE_ITEMS);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d adds and %0d multiplies, three idle mixes, %0d-cycle hold",
			add_count, mul_count, HOLD_CYCLES);
		$display("by status: ok %0d, zero/underflow %0d, special %0d, overflow %0d",
			status_seen[mfam_pkg::ST_OK], status_seen[mfam_pkg::ST_ZERO],
			status_seen[mfam_pkg::ST_SPECIAL], status_seen[mfam_pkg::ST_OVER]);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/mfam_pkg.sv
sv/mfam_core.sv
sv/minifloat_add_mul_unit.sv
sv/mfam_checker.sv
verif/tb_minifloat_add_mul_unit.sv
